// File: sv/ictu_pkg.sv
// ----------------------------------------------------------------------------
// In-order completion tracker package
// Shared sizes, request and result types, state and operation codes.
// ----------------------------------------------------------------------------
package ictu_pkg;

    // Ring size and derived widths.
    localparam int DEPTH   = 64;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result.
    localparam int TAG_W   = 6;
    localparam int COUNT_W = 7;
    localparam int LIMIT_W = 7;

    // The shared unit must hold occupancy plus a full batch count.
    localparam int ALU_W   = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
    localparam logic [ALU_W-1:0] DEPTH_A = ALU_W'(DEPTH);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_SYNC,
        S_READ,
        S_TEST,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_ADD_MOD,
        ALU_SUB_MOD
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             gt;
        logic             lt;
    } t_alu_rsp;

    typedef struct packed {
        t_action            action;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] batch_count;
        logic               is_sync;
    } t_request;

    typedef struct packed {
        logic               accepted;
        logic               limit_fault;
        logic [TAG_W-1:0]   first_tag;
        logic [COUNT_W-1:0] retired_count;
        logic [COUNT_W-1:0] pending_count;
        logic [TAG_W-1:0]   head_tag;
        logic               client_synchronized;
        logic               can_send_full;
        logic               can_initialize_full;
        logic               ignored;
    } t_result;

endpackage

// File: sv/in_order_completion_tracker_unit.sv
// ----------------------------------------------------------------------------
// In-order completion tracker
// Reserves page tags in issue order and retires them in order as they finish.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Action start batch
//   reserves batch_count tags at the tail if the outstanding limit allows,
//   finish page retires the head (and drains done entries behind it), marks
//   another pending tag done or ignores a tag that is not pending, and query
//   tag reports whether the tag may send full. Each request yields one result
//   on o_result, shown for one cycle with o_result_valid; the receiver cannot
//   stall it. A taken request is registered and evaluated; query and unused
//   codes then give their result, start batch and finish pass a check step
//   first (an accepted sync batch adds a sync step), and a finish of the head
//   walks the entries behind it, a read step and a test step for each, until
//   one is found unfinished or the ring is empty. busy falls in the cycle
//   after the strobe. The cost is set by the one shared ring unit and by the
//   registered read of the done-mark memory, which the drain walk visits one
//   entry at a time. The outstanding limit is written on its own channel,
//   always ready. Reset restores the limit to 64 and then runs a clearing
//   pass over all DEPTH entries of the done-mark memory, during which busy
//   stays high.
// ----------------------------------------------------------------------------
module in_order_completion_tracker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ictu_pkg::t_request             i_request,
    output logic                           o_result_valid,
    output ictu_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ictu_pkg::LIMIT_W-1:0]   i_cfg_data
);

    ictu_pkg::t_state   r_state, n_state;
    ictu_pkg::t_request r_req, n_req;

    logic [ictu_pkg::PTR_W-1:0]   r_head, n_head;
    logic [ictu_pkg::CNT_W-1:0]   r_occ, n_occ;
    logic                         r_sync_valid, n_sync_valid;
    logic [ictu_pkg::PTR_W-1:0]   r_sync_tag, n_sync_tag;
    logic                         r_synced, n_synced;
    logic [ictu_pkg::LIMIT_W-1:0] r_limit;
    logic [ictu_pkg::PTR_W-1:0]   r_clr, n_clr;
    logic [ictu_pkg::PTR_W-1:0]   r_tail, n_tail;
    logic                         r_pending, n_pending;

    logic                         r_accepted, n_accepted;
    logic                         r_fault, n_fault;
    logic [ictu_pkg::CNT_W-1:0]   r_retired, n_retired;
    logic                         r_ignored, n_ignored;
    logic                         r_send_full, n_send_full;

    ictu_pkg::t_alu_req alu_req;
    ictu_pkg::t_alu_rsp alu_rsp;

    logic                         ram_we;
    logic [ictu_pkg::PTR_W-1:0]   ram_waddr;
    logic [0:0]                   ram_wdata;
    logic [0:0]                   ram_rdata;

    logic                         req_take;
    logic                         tag_is_head;
    logic                         tag_in_ring;
    logic [ictu_pkg::ALU_W-1:0]   limit_eff;
    logic [ictu_pkg::ALU_W-1:0]   count_ext;

    // Request acceptance and small decodes.
    assign busy        = (r_state != ictu_pkg::S_IDLE);
    assign req_take    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign tag_is_head = (ictu_pkg::ALU_W'(r_req.tag) == ictu_pkg::ALU_W'(r_head));
    assign tag_in_ring = (ictu_pkg::ALU_W'(r_req.tag) < ictu_pkg::DEPTH_A);
    assign count_ext   = ictu_pkg::ALU_W'(r_req.batch_count);
    assign limit_eff   = (ictu_pkg::ALU_W'(r_limit) < ictu_pkg::DEPTH_A) ?
                         ictu_pkg::ALU_W'(r_limit) : ictu_pkg::DEPTH_A;

    // Shared ring arithmetic.
    ictu_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Done marks, one bit per ring slot.
    ictu_ram #(
        .WIDTH (1),
        .DEPTH (ictu_pkg::DEPTH)
    ) u_done_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ictu_pkg::S_CLEAR: begin
                if (r_clr == ictu_pkg::PTR_W'(ictu_pkg::DEPTH - 1)) begin
                    n_state = ictu_pkg::S_IDLE;
                end
            end
            ictu_pkg::S_IDLE: begin
                if (req_take) begin
                    n_state = ictu_pkg::S_EVAL;
                end
            end
            ictu_pkg::S_EVAL: begin
                if (r_req.action == ictu_pkg::ACT_START ||
                    r_req.action == ictu_pkg::ACT_FINISH) begin
                    n_state = ictu_pkg::S_CHECK;
                end else begin
                    n_state = ictu_pkg::S_DONE;
                end
            end
            ictu_pkg::S_CHECK: begin
                n_state = ictu_pkg::S_DONE;
                if (r_req.action == ictu_pkg::ACT_START) begin
                    if (!alu_rsp.gt && r_req.is_sync && r_req.batch_count != '0) begin
                        n_state = ictu_pkg::S_SYNC;
                    end
                end else if (r_pending && tag_is_head &&
                             r_occ != ictu_pkg::CNT_W'(1)) begin
                    n_state = ictu_pkg::S_READ;
                end
            end
            ictu_pkg::S_SYNC: begin
                n_state = ictu_pkg::S_DONE;
            end
            ictu_pkg::S_READ: begin
                n_state = ictu_pkg::S_TEST;
            end
            ictu_pkg::S_TEST: begin
                if (ram_rdata[0] && r_occ != ictu_pkg::CNT_W'(1)) begin
                    n_state = ictu_pkg::S_READ;
                end else begin
                    n_state = ictu_pkg::S_DONE;
                end
            end
            ictu_pkg::S_DONE: begin
                n_state = ictu_pkg::S_IDLE;
            end
            default: begin
                n_state = ictu_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control for each sequencer step.
    always_comb begin
        n_req        = r_req;
        n_head       = r_head;
        n_occ        = r_occ;
        n_sync_valid = r_sync_valid;
        n_sync_tag   = r_sync_tag;
        n_synced     = r_synced;
        n_clr        = r_clr;
        n_tail       = r_tail;
        n_pending    = r_pending;
        n_accepted   = r_accepted;
        n_fault      = r_fault;
        n_retired    = r_retired;
        n_ignored    = r_ignored;
        n_send_full  = r_send_full;
        alu_req      = '{op: ictu_pkg::ALU_ADD, a: '0, b: '0, c: '0};
        ram_we       = 1'b0;
        ram_waddr    = r_head;
        ram_wdata    = 1'b0;

        unique case (r_state)
            ictu_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + ictu_pkg::PTR_W'(1);
            end
            ictu_pkg::S_IDLE: begin
                if (req_take) begin
                    n_req       = i_request;
                    n_accepted  = 1'b0;
                    n_fault     = 1'b0;
                    n_retired   = '0;
                    n_ignored   = 1'b0;
                    n_send_full = 1'b0;
                end
            end
            ictu_pkg::S_EVAL: begin
                unique case (r_req.action)
                    ictu_pkg::ACT_START: begin
                        // Tail slot: head plus occupancy around the ring.
                        alu_req = '{op: ictu_pkg::ALU_ADD_MOD,
                                    a: ictu_pkg::ALU_W'(r_head),
                                    b: ictu_pkg::ALU_W'(r_occ),
                                    c: '0};
                        n_tail  = ictu_pkg::PTR_W'(alu_rsp.res);
                    end
                    ictu_pkg::ACT_FINISH: begin
                        // Pending when the ring distance from the head is below occupancy.
                        alu_req   = '{op: ictu_pkg::ALU_SUB_MOD,
                                      a: ictu_pkg::ALU_W'(r_req.tag),
                                      b: ictu_pkg::ALU_W'(r_head),
                                      c: ictu_pkg::ALU_W'(r_occ)};
                        n_pending = tag_in_ring && alu_rsp.lt;
                    end
                    ictu_pkg::ACT_QUERY: begin
                        n_send_full = (r_occ != '0) && tag_is_head && r_synced;
                    end
                    ictu_pkg::ACT_NONE: begin
                        n_send_full = 1'b0;
                    end
                    default: begin
                        n_send_full = 1'b0;
                    end
                endcase
            end
            ictu_pkg::S_CHECK: begin
                if (r_req.action == ictu_pkg::ACT_START) begin
                    // Limit check on the new occupancy.
                    alu_req = '{op: ictu_pkg::ALU_ADD,
                                a: ictu_pkg::ALU_W'(r_occ),
                                b: count_ext,
                                c: limit_eff};
                    if (alu_rsp.gt) begin
                        n_fault = 1'b1;
                    end else begin
                        n_accepted = 1'b1;
                        n_occ      = ictu_pkg::CNT_W'(alu_rsp.res);
                    end
                end else if (!r_pending) begin
                    n_ignored = 1'b1;
                end else if (tag_is_head) begin
                    // Retire the head.
                    alu_req   = '{op: ictu_pkg::ALU_ADD_MOD,
                                  a: ictu_pkg::ALU_W'(r_head),
                                  b: ictu_pkg::ALU_W'(1),
                                  c: '0};
                    ram_we    = 1'b1;
                    n_head    = ictu_pkg::PTR_W'(alu_rsp.res);
                    n_occ     = r_occ - ictu_pkg::CNT_W'(1);
                    n_retired = r_retired + ictu_pkg::CNT_W'(1);
                    if (r_sync_valid && r_head == r_sync_tag) begin
                        n_synced     = 1'b1;
                        n_sync_valid = 1'b0;
                    end
                end else begin
                    // Out-of-order finish: mark the entry done.
                    ram_we    = 1'b1;
                    ram_waddr = ictu_pkg::PTR_W'(r_req.tag);
                    ram_wdata = 1'b1;
                end
            end
            ictu_pkg::S_SYNC: begin
                // The last tag of the batch becomes the sync tag.
                alu_req      = '{op: ictu_pkg::ALU_ADD_MOD,
                                 a: ictu_pkg::ALU_W'(r_tail),
                                 b: count_ext - ictu_pkg::ALU_W'(1),
                                 c: '0};
                n_sync_tag   = ictu_pkg::PTR_W'(alu_rsp.res);
                n_sync_valid = 1'b1;
            end
            ictu_pkg::S_READ: begin
                // The memory read of the new head is under way.
                ram_we = 1'b0;
            end
            ictu_pkg::S_TEST: begin
                if (ram_rdata[0]) begin
                    // Drain a head that already finished.
                    alu_req   = '{op: ictu_pkg::ALU_ADD_MOD,
                                  a: ictu_pkg::ALU_W'(r_head),
                                  b: ictu_pkg::ALU_W'(1),
                                  c: '0};
                    ram_we    = 1'b1;
                    n_head    = ictu_pkg::PTR_W'(alu_rsp.res);
                    n_occ     = r_occ - ictu_pkg::CNT_W'(1);
                    n_retired = r_retired + ictu_pkg::CNT_W'(1);
                    if (r_sync_valid && r_head == r_sync_tag) begin
                        n_synced     = 1'b1;
                        n_sync_valid = 1'b0;
                    end
                end
            end
            ictu_pkg::S_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control and tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ictu_pkg::S_CLEAR;
            r_clr        <= '0;
            r_head       <= '0;
            r_occ        <= '0;
            r_sync_valid <= 1'b0;
            r_sync_tag   <= '0;
            r_synced     <= 1'b0;
            r_limit      <= ictu_pkg::LIMIT_RESET;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_head       <= n_head;
            r_occ        <= n_occ;
            r_sync_valid <= n_sync_valid;
            r_sync_tag   <= n_sync_tag;
            r_synced     <= n_synced;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_tail      <= n_tail;
        r_pending   <= n_pending;
        r_accepted  <= n_accepted;
        r_fault     <= n_fault;
        r_retired   <= n_retired;
        r_ignored   <= n_ignored;
        r_send_full <= n_send_full;
    end

    // Result strobe and fields.
    assign o_result_valid                = (r_state == ictu_pkg::S_DONE);
    assign o_result.accepted             = r_accepted;
    assign o_result.limit_fault          = r_fault;
    assign o_result.first_tag            = r_accepted ? ictu_pkg::TAG_W'(r_tail) : '0;
    assign o_result.retired_count        = ictu_pkg::COUNT_W'(r_retired);
    assign o_result.pending_count        = ictu_pkg::COUNT_W'(r_occ);
    assign o_result.head_tag             = ictu_pkg::TAG_W'(r_head);
    assign o_result.client_synchronized  = r_synced;
    assign o_result.can_send_full        = r_send_full;
    assign o_result.can_initialize_full  = (r_occ == '0) && r_synced;
    assign o_result.ignored              = r_ignored;

    // Occupancy never exceeds the ring.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= ictu_pkg::CNT_W'(ictu_pkg::DEPTH))
        else $error("occupancy exceeds ring size");

    // A result strobe lasts exactly one cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    // A batch is either accepted or faulted, never both.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.accepted && o_result.limit_fault))
        else $error("batch both accepted and faulted");

    // A taken request makes the block busy in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> busy)
        else $error("request taken without going busy");

    // An ignored finish retires nothing.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.ignored) |-> (o_result.retired_count == '0))
        else $error("ignored finish reported retirements");

    // Each drain step retires exactly one entry.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ictu_pkg::S_TEST && ram_rdata[0]) |=>
        (r_occ == $past(r_occ) - ictu_pkg::CNT_W'(1)))
        else $error("drain step did not retire one entry");

endmodule

// File: sv/ictu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ictu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/ictu_alu.sv
// ----------------------------------------------------------------------------
// Tracker ring arithmetic unit
// Shared add, ring add and ring distance with a compare against a bound.
// ----------------------------------------------------------------------------
module ictu_alu (
    input  ictu_pkg::t_alu_req i_req,
    output ictu_pkg::t_alu_rsp o_rsp
);

    logic [ictu_pkg::ALU_W-1:0] sum;
    logic [ictu_pkg::ALU_W-1:0] diff;
    logic [ictu_pkg::ALU_W-1:0] res;

    assign sum  = i_req.a + i_req.b;
    assign diff = i_req.a - i_req.b;

    // Ring operands stay below twice the ring size, so one correction suffices.
    always_comb begin
        unique case (i_req.op)
            ictu_pkg::ALU_ADD: begin
                res = sum;
            end
            ictu_pkg::ALU_ADD_MOD: begin
                res = (sum >= ictu_pkg::DEPTH_A) ? (sum - ictu_pkg::DEPTH_A) : sum;
            end
            ictu_pkg::ALU_SUB_MOD: begin
                res = (i_req.a < i_req.b) ? (diff + ictu_pkg::DEPTH_A) : diff;
            end
            default: begin
                res = sum;
            end
        endcase
    end

    assign o_rsp.res = res;
    assign o_rsp.gt  = (res > i_req.c);
    assign o_rsp.lt  = (res < i_req.c);

endmodule
